// File: hw/rtl/pip_pkg.sv
// Shared types and constants for the point-in-polygon crossing-number block.
// No dependencies.
package pip_pkg;

  localparam int MAX_VERTICES_DEF = 256;
  localparam int COORD_BITS_DEF   = 32;
  localparam int PORT_BITS        = 32;
  localparam int EDGE_LAT         = 3;

  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_QUERY  = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ROT   = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  typedef struct packed {
    logic shift;
    logic rotate;
  } cell_ctl_t;

endpackage

// File: hw/rtl/point_in_polygon_ray_cast.sv
// Point-in-polygon by crossing number over one stored ring held in a chain of
// vertex cells. Depends on pip_pkg, pip_cell, pip_edge.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+---------------------------
//  command | opcode, coord_x, coord_y                | start & !busy
//  result  | inside_res, point_x, point_y,           | done, one cycle, no stall
//          | ring_overflowed                         |
//
// Append and clear leave busy low. A query with N stored vertices rotates the
// chain once, one edge per cycle, then drains the three-stage edge pipe and
// transfers the result (a query with N < 2 skips the rotation). busy stays
// high through the done cycle and drops right after.
// Synchronous reset empties the ring and clears the overflow flag.
module point_in_polygon_ray_cast #(
  parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF,
  parameter int COORD_BITS   = pip_pkg::COORD_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [1:0]                           opcode,
  input  logic signed [pip_pkg::PORT_BITS-1:0] coord_x,
  input  logic signed [pip_pkg::PORT_BITS-1:0] coord_y,
  output logic                                 done,
  output logic                                 inside_res,
  output logic signed [pip_pkg::PORT_BITS-1:0] point_x,
  output logic signed [pip_pkg::PORT_BITS-1:0] point_y,
  output logic                                 ring_overflowed
);
  import pip_pkg::*;

  localparam int CW    = COORD_BITS;
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);
  localparam int TAKE  = (COORD_BITS < PORT_BITS) ? COORD_BITS : PORT_BITS;
  localparam int DR_W  = $clog2(EDGE_LAT);

  state_t               state;
  logic [CNT_W-1:0]     count, count_m1, step;
  logic [DR_W-1:0]      drain;
  logic                 dropped, parity, hit, full;
  logic signed [CW-1:0] in_x, in_y, px, py;
  cell_ctl_t            ctl;

  logic signed [CW-1:0] cell_x [MAX_VERTICES];
  logic signed [CW-1:0] cell_y [MAX_VERTICES];

  assign in_x     = CW'($signed(coord_x[TAKE-1:0]));
  assign in_y     = CW'($signed(coord_y[TAKE-1:0]));
  assign count_m1 = count - 1'b1;
  assign full     = (count == CNT_W'(MAX_VERTICES));

  assign ctl.shift  = (state == ST_IDLE) && start && (opcode == OP_APPEND) && !full;
  assign ctl.rotate = (state == ST_ROT);

  genvar i;
  generate
    for (i = 0; i < MAX_VERTICES; i++) begin : g_cell
      logic signed [CW-1:0] lx, ly, rx, ry;
      if (i == 0) begin : g_head
        assign lx = in_x;
        assign ly = in_y;
      end else begin : g_body
        assign lx = cell_x[i-1];
        assign ly = cell_y[i-1];
      end
      if (i == MAX_VERTICES - 1) begin : g_tail
        assign rx = cell_x[0];
        assign ry = cell_y[0];
      end else begin : g_mid
        assign rx = cell_x[i+1];
        assign ry = cell_y[i+1];
      end
      pip_cell #(.CW(CW)) u_cell (
        .clk     (clk),
        .ctl     (ctl),
        .is_last (count_m1 == CNT_W'(i)),
        .left_x  (lx),
        .left_y  (ly),
        .right_x (rx),
        .right_y (ry),
        .head_x  (cell_x[0]),
        .head_y  (cell_y[0]),
        .vx      (cell_x[i]),
        .vy      (cell_y[i])
      );
    end
  endgenerate

  pip_edge #(.CW(CW)) u_edge (
    .clk   (clk),
    .rst   (rst),
    .valid (state == ST_ROT),
    .x1    (cell_x[0]),
    .y1    (cell_y[0]),
    .x2    (cell_x[1]),
    .y2    (cell_y[1]),
    .px    (px),
    .py    (py),
    .hit   (hit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      count   <= '0;
      step    <= '0;
      drain   <= '0;
      dropped <= 1'b0;
      parity  <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            case (opcode)
              OP_APPEND: begin
                if (full) dropped <= 1'b1;
                else count <= count + 1'b1;
              end
              OP_CLEAR: begin
                count   <= '0;
                dropped <= 1'b0;
              end
              OP_QUERY: begin
                parity <= 1'b0;
                step   <= '0;
                drain  <= '0;
                state  <= (count > CNT_W'(1)) ? ST_ROT : ST_DRAIN;
              end
              default: ;
            endcase
          end
        end
        ST_ROT: begin
          if (hit) parity <= ~parity;
          step <= step + 1'b1;
          if (step == count_m1) state <= ST_DRAIN;
        end
        ST_DRAIN: begin
          if (hit) parity <= ~parity;
          drain <= drain + 1'b1;
          if (drain == DR_W'(EDGE_LAT - 1)) state <= ST_DONE;
        end
        ST_DONE: begin
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && start && (opcode == OP_QUERY)) begin
      px      <= in_x;
      py      <= in_y;
      point_x <= coord_x;
      point_y <= coord_y;
    end
  end

  assign busy            = (state != ST_IDLE);
  assign done            = (state == ST_DONE);
  assign inside_res      = parity;
  assign ring_overflowed = dropped;

endmodule

// File: hw/rtl/pip_cell.sv
// One vertex cell of the ring chain: shifts toward the tail on append,
// rotates toward the head during a query.
// Depends on pip_pkg.
module pip_cell #(
  parameter int CW = 32
) (
  input  logic                 clk,
  input  pip_pkg::cell_ctl_t   ctl,
  input  logic                 is_last,
  input  logic signed [CW-1:0] left_x,
  input  logic signed [CW-1:0] left_y,
  input  logic signed [CW-1:0] right_x,
  input  logic signed [CW-1:0] right_y,
  input  logic signed [CW-1:0] head_x,
  input  logic signed [CW-1:0] head_y,
  output logic signed [CW-1:0] vx,
  output logic signed [CW-1:0] vy
);
  import pip_pkg::*;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      vx <= left_x;
      vy <= left_y;
    end else if (ctl.rotate) begin
      vx <= is_last ? head_x : right_x;
      vy <= is_last ? head_y : right_y;
    end
  end

endmodule

// File: hw/rtl/pip_edge.sv
// Pipelined edge test: order the edge, span check, exact cross-multiplied
// compare. The edge data pass through the difference and product registers to the registered hit flag.
// Depends on pip_pkg.
module pip_edge #(
  parameter int CW = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 valid,
  input  logic signed [CW-1:0] x1,
  input  logic signed [CW-1:0] y1,
  input  logic signed [CW-1:0] x2,
  input  logic signed [CW-1:0] y2,
  input  logic signed [CW-1:0] px,
  input  logic signed [CW-1:0] py,
  output logic                 hit
);
  import pip_pkg::*;

  localparam int DW = CW + 1;
  localparam int PW = 2 * DW;

  logic signed [CW-1:0] ax, ay, bx, by;
  logic                 use_edge;
  logic                 v1, v2;
  logic signed [DW-1:0] dyp, dxe, dxp, dye;
  logic signed [PW-1:0] prod_a, prod_b;

  always_comb begin
    if (y1 > y2) begin
      ax = x2; ay = y2; bx = x1; by = y1;
    end else begin
      ax = x1; ay = y1; bx = x2; by = y2;
    end
    use_edge = valid && (y1 != y2) && (py >= ay) && (py < by);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      v2  <= 1'b0;
      hit <= 1'b0;
    end else begin
      v1  <= use_edge;
      v2  <= v1;
      hit <= v2 && (prod_a > prod_b);
    end
  end

  always_ff @(posedge clk) begin
    dyp    <= DW'(py) - DW'(ay);
    dxe    <= DW'(bx) - DW'(ax);
    dxp    <= DW'(px) - DW'(ax);
    dye    <= DW'(by) - DW'(ay);
    prod_a <= PW'(dyp) * PW'(dxe);
    prod_b <= PW'(dxp) * PW'(dye);
  end

endmodule

// File: hw/rtl/pip_checker.sv
// Port-level checks for point_in_polygon_ray_cast, attached by bind.
// Depends on pip_pkg and point_in_polygon_ray_cast.
module pip_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [1:0] opcode,
  input logic       done
);
  import pip_pkg::*;

  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("done without busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done longer than one cycle");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && opcode == OP_QUERY) |=> busy)
    else $error("query transfer did not raise busy");

  a_cmd_quick: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && opcode != OP_QUERY) |=> !busy)
    else $error("append or clear raised busy");

  a_end_done: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $fell(busy)) |-> $past(done))
    else $error("busy dropped without a result");

endmodule

bind point_in_polygon_ray_cast pip_checker u_pip_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .opcode (opcode),
  .done   (done)
);

// File: sim/pip_checker.sv
`timescale 1ns / 100ps
// Checker for point_in_polygon_ray_cast: watches command and result transfers,
// keeps its own copy of the ring, predicts each query answer and compares.
// Depends on pip_pkg.
module pip_tb_checker
  import pip_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        busy,
  input  logic [1:0]                  opcode,
  input  logic signed [PORT_BITS-1:0] coord_x,
  input  logic signed [PORT_BITS-1:0] coord_y,
  input  logic                        done,
  input  logic                        inside_res,
  input  logic signed [PORT_BITS-1:0] point_x,
  input  logic signed [PORT_BITS-1:0] point_y,
  input  logic                        ring_overflowed,
  output int                          n_fail,
  output int                          n_pending,
  output int                          n_checked,
  output int                          n_inside,
  output int                          n_overflowed
);

  typedef struct {
    logic                        in_ring;
    logic signed [PORT_BITS-1:0] px;
    logic signed [PORT_BITS-1:0] py;
    logic                        overflowed;
  } query_answer_t;

  logic signed [PORT_BITS-1:0] ring_x [MAX_VERTICES_DEF];
  logic signed [PORT_BITS-1:0] ring_y [MAX_VERTICES_DEF];
  int unsigned   vertex_total = 0;
  logic          dropped = 1'b0;
  query_answer_t expected_answers[$];
  int            fails = 0;
  int            checked = 0;
  int            inside_seen = 0;
  int            ovf_seen = 0;

  // odd crossing count over the whole closed ring, exact wide compare
  function automatic logic crossing_parity(input logic signed [PORT_BITS-1:0] qx, qy);
    logic signed [127:0] px, py, x1, y1, x2, y2, t;
    int unsigned         k;
    logic                parity;
    parity = 1'b0;
    px = qx;
    py = qy;
    for (int unsigned j = 0; j < vertex_total; j++) begin
      k = (j + 1 < vertex_total) ? j + 1 : 0;
      x1 = ring_x[j];
      y1 = ring_y[j];
      x2 = ring_x[k];
      y2 = ring_y[k];
      if (y1 == y2) continue;
      if (y1 > y2) begin
        t = x1; x1 = x2; x2 = t;
        t = y1; y1 = y2; y2 = t;
      end
      if (py >= y1 && py < y2 && (py - y1) * (x2 - x1) > (px - x1) * (y2 - y1))
        parity = ~parity;
    end
    return parity;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, got);
    if (got !== want) begin
      $error("%s mismatch: expected %h, got %h", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin : watch
    query_answer_t want;
    query_answer_t answer;
    if (rst) begin
      vertex_total = 0;
      dropped = 1'b0;
    end else begin
      if (done === 1'b1) begin
        if (expected_answers.size() == 0) begin
          $error("result transfer with no query outstanding: point_x %h point_y %h",
                 point_x, point_y);
          fails++;
        end else begin
          want = expected_answers.pop_front();
          check_field("inside_res", want.in_ring, inside_res);
          check_field("point_x", want.px, point_x);
          check_field("point_y", want.py, point_y);
          check_field("ring_overflowed", want.overflowed, ring_overflowed);
          checked++;
          if (want.in_ring) inside_seen++;
          if (want.overflowed) ovf_seen++;
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        case (opcode)
          OP_APPEND: begin
            if (vertex_total < MAX_VERTICES_DEF) begin
              ring_x[vertex_total] = coord_x;
              ring_y[vertex_total] = coord_y;
              vertex_total++;
            end else begin
              dropped = 1'b1;
            end
          end
          OP_CLEAR: begin
            vertex_total = 0;
            dropped = 1'b0;
          end
          OP_QUERY: begin
            answer.in_ring = crossing_parity(coord_x, coord_y);
            answer.px = coord_x;
            answer.py = coord_y;
            answer.overflowed = dropped;
            expected_answers = {expected_answers, answer};
          end
          default: ;
        endcase
      end
    end
    n_fail       <= fails;
    n_pending    <= expected_answers.size();
    n_checked    <= checked;
    n_inside     <= inside_seen;
    n_overflowed <= ovf_seen;
  end

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps
// Testbench top for point_in_polygon_ray_cast: directed and random command
// stimulus with random gaps; checking is done by pip_tb_checker.
// Depends on pip_pkg, pip_tb_checker and the block's RTL.
module tb;
  import pip_pkg::*;

  localparam int          ITEMS       = 1250;
  localparam int          CYCLE_LIMIT = 3_000_000;
  localparam int          TAIL_CYCLES = MAX_VERTICES_DEF + 40;
  localparam logic [1:0]  OP_UNUSED   = 2'd3;
  localparam logic [31:0] COORD_MIN   = 32'h8000_0000;
  localparam logic [31:0] COORD_MAX   = 32'h7fff_ffff;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        start = 1'b0;
  logic [1:0]                  opcode = OP_APPEND;
  logic signed [PORT_BITS-1:0] coord_x = '0;
  logic signed [PORT_BITS-1:0] coord_y = '0;
  logic                        busy;
  logic                        done;
  logic                        inside_res;
  logic signed [PORT_BITS-1:0] point_x;
  logic signed [PORT_BITS-1:0] point_y;
  logic                        ring_overflowed;

  int n_fail, n_pending, n_checked, n_inside, n_overflowed;
  int cycles = 0;
  int n_append = 0, n_query = 0, n_clear = 0, n_ignored = 0;
  bit calm = 1'b0;
  int coord_mode = 1;
  logic [31:0] ring_vx[$], ring_vy[$];

  always #2 clk = ~clk;

  point_in_polygon_ray_cast i_dut (
    .clk, .rst, .start, .busy, .opcode, .coord_x, .coord_y,
    .done, .inside_res, .point_x, .point_y, .ring_overflowed
  );

  pip_tb_checker i_checker (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles, n_pending);
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] pick_coord(input int mode);
    case (mode)
      0: return 32'($urandom_range(0, 16)) - 32'd8;
      1: return {16'($urandom_range(0, 2000) - 1000), 16'($urandom_range(0, 65535))};
      2: return $urandom();
      default: begin
        case ($urandom_range(0, 4))
          0: return COORD_MIN;
          1: return COORD_MAX;
          2: return 32'h0;
          3: return 32'hffff_ffff;
          default: return 32'h1;
        endcase
      end
    endcase
  endfunction

  // start stays high from one transfer into the next when there is no gap
  task automatic send(input logic [1:0] op, input logic [31:0] x, y);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    opcode  <= op;
    coord_x <= x;
    coord_y <= y;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    case (op)
      OP_APPEND: n_append++;
      OP_QUERY:  n_query++;
      OP_CLEAR:  n_clear++;
      default:   n_ignored++;
    endcase
  endtask

  task automatic add_vertex(input logic [31:0] x, y);
    send(OP_APPEND, x, y);
    ring_vx = {ring_vx, x};
    ring_vy = {ring_vy, y};
  endtask

  task automatic clear_ring();
    send(OP_CLEAR, $urandom(), $urandom());
    ring_vx.delete();
    ring_vy.delete();
  endtask

  // query points often sit on a vertex y or near the ring's interior
  task automatic send_query();
    logic [31:0] qx, qy;
    longint      sx, sy;
    int          r, n, a;
    qx = pick_coord(coord_mode);
    qy = pick_coord(coord_mode);
    n = ring_vx.size();
    r = $urandom_range(0, 99);
    if (n > 0 && r < 40) begin
      qy = ring_vy[$urandom_range(0, n - 1)];
      if (r < 15) qx = ring_vx[$urandom_range(0, n - 1)];
    end else if (n > 0 && r < 70) begin
      sx = 0;
      sy = 0;
      repeat (3) begin
        a = $urandom_range(0, n - 1);
        sx += longint'(signed'(ring_vx[a]));
        sy += longint'(signed'(ring_vy[a]));
      end
      qx = 32'(sx / 3);
      qy = 32'(sy / 3);
    end
    send(OP_QUERY, qx, qy);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
  endtask

  initial begin
    int  nv, r, fills;
    bit  first;
    fills = 0;
    first = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty ring, single vertex, two-vertex ring
    send(OP_QUERY, 32'h0, 32'h0);
    send(OP_APPEND, 32'h0, 32'h0);
    send(OP_QUERY, 32'h0, 32'h0);
    send(OP_APPEND, COORD_MAX, COORD_MAX);
    send(OP_QUERY, 32'h1, 32'h1);
    send(OP_CLEAR, 32'h0, 32'h0);
    // full-scale triangle with a horizontal bottom edge
    send(OP_APPEND, COORD_MIN, COORD_MIN);
    send(OP_APPEND, COORD_MAX, COORD_MIN);
    send(OP_APPEND, 32'h0, COORD_MAX);
    send(OP_QUERY, 32'h0, 32'h0);
    send(OP_QUERY, COORD_MIN, COORD_MIN);
    send(OP_QUERY, 32'hffff_ffff, COORD_MIN);
    send(OP_QUERY, 32'h0, COORD_MAX);
    send(OP_QUERY, COORD_MAX, 32'h7fff_fffe);
    send(OP_QUERY, COORD_MIN, 32'h0);
    // unused opcode must leave the ring alone
    send(OP_UNUSED, 32'hffff_ffff, 32'hffff_ffff);
    send(OP_QUERY, 32'h0, 32'h0);
    send(OP_CLEAR, 32'hffff_ffff, 32'hffff_ffff);
    send(OP_QUERY, 32'h0, 32'h0);
    drain();

    while (n_append + n_query + n_clear < ITEMS) begin
      calm = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      coord_mode = (r < 15) ? 0 : (r < 60) ? 1 : (r < 85) ? 2 : 3;
      r = $urandom_range(0, 199);
      if (first || (r == 0 && fills < 2)) begin
        nv = MAX_VERTICES_DEF + $urandom_range(1, 3);
        fills++;
      end else if (r < 20) begin
        nv = $urandom_range(13, 64);
      end else begin
        nv = $urandom_range(0, 12);
      end
      // mostly fresh rings; sometimes keep appending onto the old one
      if (first || $urandom_range(0, 9) != 0) clear_ring();
      first = 1'b0;
      repeat (nv) begin
        if ($urandom_range(0, 29) == 0) send(OP_UNUSED, $urandom(), $urandom());
        add_vertex(pick_coord(coord_mode), pick_coord(coord_mode));
      end
      repeat ($urandom_range(1, 8)) send_query();
      if ($urandom_range(0, 19) == 0) drain();
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d appends, %0d queries, %0d clears, %0d unused-opcode commands",
             n_append, n_query, n_clear, n_ignored);
    $display("Checked %0d query answers: %0d inside, %0d with overflow flagged",
             n_checked, n_inside, n_overflowed);
    if (n_fail == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: point_in_polygon_ray_cast.f
hw/rtl/pip_pkg.sv
hw/rtl/pip_cell.sv
hw/rtl/pip_edge.sv
hw/rtl/point_in_polygon_ray_cast.sv
hw/rtl/pip_checker.sv
sim/pip_checker.sv
sim/tb.sv
